### rtl/clock_set_key_fsm_macros.svh
// assertion macros used by the checker file
`ifndef CLOCK_SET_KEY_FSM_MACROS_SVH
`define CLOCK_SET_KEY_FSM_MACROS_SVH

// same-cycle implication, off while reset is low
`define CSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define CSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/csk_pkg.sv
package csk_pkg;

    // brightness range
    localparam int MAX_LEVEL   = 7;
    localparam int BRIGHT_CEIL = 7;
    localparam logic signed [3:0] BRIGHT_TOP =
        4'((MAX_LEVEL > BRIGHT_CEIL) ? BRIGHT_CEIL : MAX_LEVEL);
    localparam logic signed [3:0] BRIGHT_OFF = -4'sd1;

    // field limits
    localparam int HOUR_MAX   = 23;
    localparam int MINUTE_MAX = 59;
    localparam int DAY_MAX    = 31;
    localparam int MONTH_MAX  = 12;
    localparam int YEAR_MAX   = 99;
    localparam int WDAY_MAX   = 6;

    // key codes, one-hot
    localparam logic [7:0] KEY_VIEW   = 8'h01;
    localparam logic [7:0] KEY_EDIT   = 8'h02;
    localparam logic [7:0] KEY_PREV   = 8'h04;
    localparam logic [7:0] KEY_NEXT   = 8'h08;
    localparam logic [7:0] KEY_DOWN   = 8'h10;
    localparam logic [7:0] KEY_UP     = 8'h20;
    localparam logic [7:0] KEY_DIM    = 8'h40;
    localparam logic [7:0] KEY_BRIGHT = 8'h80;

    // field selector codes
    localparam logic [2:0] SEL_HOUR    = 3'd0;
    localparam logic [2:0] SEL_MINUTE  = 3'd1;
    localparam logic [2:0] SEL_SECOND  = 3'd2;
    localparam logic [2:0] SEL_DAY     = 3'd3;
    localparam logic [2:0] SEL_MONTH   = 3'd4;
    localparam logic [2:0] SEL_YEAR    = 3'd5;
    localparam logic [2:0] SEL_WEEKDAY = 3'd6;

    // calendar and time registers
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       century;
        logic [2:0] weekday;
    } t_clock;

    // full register snapshot carried by one result item
    typedef struct packed {
        t_clock             clk;
        logic               view_time;
        logic               edit;
        logic [2:0]         sel;
        logic signed [3:0]  bright;
    } t_snap;

    // step up, wrapping to lo at or above hi
    function automatic logic [6:0] wrap_up(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        return (v < hi) ? v + 7'd1 : lo;
    endfunction

    // step down, wrapping to hi at or below lo
    function automatic logic [6:0] wrap_down(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
        return (v > lo) ? v - 7'd1 : hi;
    endfunction

endpackage

### rtl/csk_field_step.sv
module csk_field_step (
    input  csk_pkg::t_clock i_cur,
    input  logic [2:0]      i_sel,
    input  logic            i_up,
    output csk_pkg::t_clock o_next
);

    logic [6:0] w_hour;
    logic [6:0] w_minute;
    logic [6:0] w_second;
    logic [6:0] w_day;
    logic [6:0] w_month;
    logic [6:0] w_wday;

    // wrapped candidates for every field
    always_comb begin
        if (i_up) begin
            w_hour   = csk_pkg::wrap_up(7'(i_cur.hour), 7'd0, 7'(csk_pkg::HOUR_MAX));
            w_minute = csk_pkg::wrap_up(7'(i_cur.minute), 7'd0, 7'(csk_pkg::MINUTE_MAX));
            w_second = csk_pkg::wrap_up(7'(i_cur.second), 7'd0, 7'(csk_pkg::MINUTE_MAX));
            w_day    = csk_pkg::wrap_up(7'(i_cur.day), 7'd1, 7'(csk_pkg::DAY_MAX));
            w_month  = csk_pkg::wrap_up(7'(i_cur.month), 7'd1, 7'(csk_pkg::MONTH_MAX));
            // weekday runs the other way
            w_wday   = csk_pkg::wrap_down(7'(i_cur.weekday), 7'd0, 7'(csk_pkg::WDAY_MAX));
        end else begin
            w_hour   = csk_pkg::wrap_down(7'(i_cur.hour), 7'd0, 7'(csk_pkg::HOUR_MAX));
            w_minute = csk_pkg::wrap_down(7'(i_cur.minute), 7'd0, 7'(csk_pkg::MINUTE_MAX));
            w_second = csk_pkg::wrap_down(7'(i_cur.second), 7'd0, 7'(csk_pkg::MINUTE_MAX));
            w_day    = csk_pkg::wrap_down(7'(i_cur.day), 7'd1, 7'(csk_pkg::DAY_MAX));
            w_month  = csk_pkg::wrap_down(7'(i_cur.month), 7'd1, 7'(csk_pkg::MONTH_MAX));
            w_wday   = csk_pkg::wrap_up(7'(i_cur.weekday), 7'd0, 7'(csk_pkg::WDAY_MAX));
        end
    end

    // apply the step to the selected field only
    always_comb begin
        o_next = i_cur;
        case (i_sel)
            csk_pkg::SEL_HOUR:    o_next.hour    = w_hour[4:0];
            csk_pkg::SEL_MINUTE:  o_next.minute  = w_minute[5:0];
            csk_pkg::SEL_SECOND:  o_next.second  = w_second[5:0];
            csk_pkg::SEL_DAY:     o_next.day     = w_day[4:0];
            csk_pkg::SEL_MONTH:   o_next.month   = w_month[3:0];
            csk_pkg::SEL_YEAR: begin
                // year wrap flips the century
                if (i_up) begin
                    if (i_cur.year < 7'(csk_pkg::YEAR_MAX)) begin
                        o_next.year = i_cur.year + 7'd1;
                    end else begin
                        o_next.year    = 7'd0;
                        o_next.century = ~i_cur.century;
                    end
                end else begin
                    if (i_cur.year > 7'd0) begin
                        o_next.year = i_cur.year - 7'd1;
                    end else begin
                        o_next.year    = 7'(csk_pkg::YEAR_MAX);
                        o_next.century = ~i_cur.century;
                    end
                end
            end
            csk_pkg::SEL_WEEKDAY: o_next.weekday = w_wday[2:0];
            default: ;
        endcase
    end

endmodule

### rtl/csk_out_buf.sv
module csk_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csk_pkg::t_snap i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output csk_pkg::t_snap o_data
);

    logic           r_out_valid;
    logic           r_skid_valid;
    csk_pkg::t_snap r_out;
    csk_pkg::t_snap r_skid;
    logic           w_take;

    assign w_take  = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    // valid flags of output and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

### rtl/clock_set_key_fsm.sv
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_keys
// output    out        o_out_valid / i_out_stall    o_hour_value .. o_brightness_level
//
// one item per cycle unless o_in_stall is high; each result is registered, in the output stage or the skid stage
// the key decode and field step sit between the state registers and the result register
// a two-entry output buffer lets one item in while a result waits; stall rises once both fill
// synchronous active-low reset: 00:00:00, 01.01.(20)00, monday, time view, full brightness
module clock_set_key_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_keys,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [4:0]        o_hour_value,
    output logic [5:0]        o_minute_value,
    output logic [5:0]        o_second_value,
    output logic [4:0]        o_day_value,
    output logic [3:0]        o_month_value,
    output logic [6:0]        o_year_value,
    output logic              o_century_flag,
    output logic [2:0]        o_weekday_value,
    output logic              o_show_time,
    output logic              o_editing,
    output logic [2:0]        o_field_select,
    output logic signed [3:0] o_brightness_level
);

    logic [7:0]        r_prev_keys;
    csk_pkg::t_clock   r_clk;
    logic              r_view;
    logic              r_edit;
    logic [2:0]        r_sel;
    logic signed [3:0] r_bright;

    csk_pkg::t_clock   n_clk;
    logic              n_view;
    logic              n_edit;
    logic [2:0]        n_sel;
    logic signed [3:0] n_bright;

    csk_pkg::t_clock   w_stepped;
    csk_pkg::t_snap    w_snap;
    csk_pkg::t_snap    w_out;
    logic              w_accept;
    logic              w_full;
    logic              w_up;

    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;
    assign w_up       = (i_keys == csk_pkg::KEY_UP);

    // selected field stepped up or down
    csk_field_step u_step (
        .i_cur  (r_clk),
        .i_sel  (r_sel),
        .i_up   (w_up),
        .o_next (w_stepped)
    );

    // key decode, acting on a changed sample only
    always_comb begin
        n_clk    = r_clk;
        n_view   = r_view;
        n_edit   = r_edit;
        n_sel    = r_sel;
        n_bright = r_bright;
        if (i_keys != r_prev_keys) begin
            case (i_keys)
                csk_pkg::KEY_VIEW: begin
                    if (!r_edit) begin
                        n_view = ~r_view;
                    end
                end
                csk_pkg::KEY_EDIT: begin
                    if (!r_edit) begin
                        n_edit = 1'b1;
                        n_sel  = csk_pkg::SEL_HOUR;
                        n_view = 1'b1;
                    end else begin
                        n_edit = 1'b0;
                    end
                end
                csk_pkg::KEY_PREV: begin
                    if (r_sel == csk_pkg::SEL_HOUR || r_sel > csk_pkg::SEL_WEEKDAY) begin
                        n_sel = csk_pkg::SEL_WEEKDAY;
                    end else begin
                        n_sel = r_sel - 3'd1;
                    end
                    n_view = (n_sel <= csk_pkg::SEL_SECOND);
                end
                csk_pkg::KEY_NEXT: begin
                    if (r_sel >= csk_pkg::SEL_WEEKDAY) begin
                        n_sel = csk_pkg::SEL_HOUR;
                    end else begin
                        n_sel = r_sel + 3'd1;
                    end
                    n_view = (n_sel <= csk_pkg::SEL_SECOND);
                end
                csk_pkg::KEY_DOWN: n_clk = w_stepped;
                csk_pkg::KEY_UP:   n_clk = w_stepped;
                csk_pkg::KEY_DIM: begin
                    if (r_bright > csk_pkg::BRIGHT_OFF) begin
                        n_bright = r_bright - 4'sd1;
                    end
                end
                csk_pkg::KEY_BRIGHT: begin
                    if (r_bright < csk_pkg::BRIGHT_TOP) begin
                        n_bright = r_bright + 4'sd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers, updated per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys   <= 8'd0;
            r_clk.hour    <= 5'd0;
            r_clk.minute  <= 6'd0;
            r_clk.second  <= 6'd0;
            r_clk.day     <= 5'd1;
            r_clk.month   <= 4'd1;
            r_clk.year    <= 7'd0;
            r_clk.century <= 1'b1;
            r_clk.weekday <= 3'd0;
            r_view        <= 1'b1;
            r_edit        <= 1'b0;
            r_sel         <= csk_pkg::SEL_HOUR;
            r_bright      <= csk_pkg::BRIGHT_TOP;
        end else if (w_accept) begin
            r_prev_keys <= i_keys;
            r_clk       <= n_clk;
            r_view      <= n_view;
            r_edit      <= n_edit;
            r_sel       <= n_sel;
            r_bright    <= n_bright;
        end
    end

    // snapshot after the update
    always_comb begin
        w_snap.clk       = n_clk;
        w_snap.view_time = n_view;
        w_snap.edit      = n_edit;
        w_snap.sel       = n_sel;
        w_snap.bright    = n_bright;
    end

    // result register with skid stage
    csk_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_snap),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    // result ports
    assign o_hour_value       = w_out.clk.hour;
    assign o_minute_value     = w_out.clk.minute;
    assign o_second_value     = w_out.clk.second;
    assign o_day_value        = w_out.clk.day;
    assign o_month_value      = w_out.clk.month;
    assign o_year_value       = w_out.clk.year;
    assign o_century_flag     = w_out.clk.century;
    assign o_weekday_value    = w_out.clk.weekday;
    assign o_show_time        = w_out.view_time;
    assign o_editing          = w_out.edit;
    assign o_field_select     = w_out.sel;
    assign o_brightness_level = w_out.bright;

endmodule

### rtl/csk_checker.sv
`include "clock_set_key_fsm_macros.svh"

module csk_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [4:0]        o_hour_value,
    input logic [5:0]        o_minute_value,
    input logic [5:0]        o_second_value,
    input logic [4:0]        o_day_value,
    input logic [3:0]        o_month_value,
    input logic [6:0]        o_year_value,
    input logic [2:0]        o_weekday_value,
    input logic [2:0]        o_field_select,
    input logic signed [3:0] o_brightness_level
);

    // a held result keeps its payload
    `CSK_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_hour_value) && $stable(o_year_value)
        && $stable(o_field_select),
        "stalled result changed")

    // every shown field stays within its range
    `CSK_ASSERT_NOW(a_range, i_clk, i_rst_n, o_out_valid,
        o_hour_value <= 5'd23 && o_minute_value <= 6'd59 && o_second_value <= 6'd59
        && o_day_value >= 5'd1 && o_month_value >= 4'd1 && o_month_value <= 4'd12
        && o_year_value <= 7'd99 && o_weekday_value <= 3'd6 && o_field_select <= 3'd6
        && (o_brightness_level[3] == 1'b0 || o_brightness_level == 4'b1111),
        "result field out of range")

    // an item taken into an empty output shows next cycle
    `CSK_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_in_valid && !o_in_stall && !o_out_valid,
        o_out_valid, "result missing after accept")

    // input stall only rises behind a stalled result
    `CSK_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall),
        $past(o_out_valid && i_out_stall), "input stall without output stall")

endmodule

bind clock_set_key_fsm csk_checker u_csk_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_hour_value       (o_hour_value),
    .o_minute_value     (o_minute_value),
    .o_second_value     (o_second_value),
    .o_day_value        (o_day_value),
    .o_month_value      (o_month_value),
    .o_year_value       (o_year_value),
    .o_weekday_value    (o_weekday_value),
    .o_field_select     (o_field_select),
    .o_brightness_level (o_brightness_level)
);
